// File: rtl/core/stereo_row_hamming_matcher_defines.svh
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_ROW_HAMMING_MATCHER_DEFINES_SVH
`define STEREO_ROW_HAMMING_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRHM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srhm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srhm assertion failed");

`endif

// File: rtl/core/srhm_pkg.sv
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher package
// Word types, codes, defaults and popcount helpers shared by the matcher.
// ----------------------------------------------------------------------------
package srhm_pkg;

    localparam int MAX_KEYPOINTS_DEF = 256;
    localparam int DESC_BITS_DEF     = 256;

    localparam int COORD_W     = 14;
    localparam int DESC_WORD_W = 64;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_OUT_W   = 8;
    localparam int DIST_OUT_W  = 9;
    localparam int TOL_W       = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int WORD_CNT_W  = 7;

    localparam logic [CFG_DATA_W-1:0] MAX_DISTANCE_RST = 9'd100;
    localparam logic [TOL_W-1:0]      ROW_TOL_RST      = 4'd0;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROW   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FAR  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LEFT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOLERANCE = 1'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [COORD_W-1:0]     x_pos;
        logic [COORD_W-1:0]     y_pos;
        logic [DESC_WORD_W-1:0] desc_word0;
        logic [DESC_WORD_W-1:0] desc_word1;
        logic [DESC_WORD_W-1:0] desc_word2;
        logic [DESC_WORD_W-1:0] desc_word3;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [IDX_OUT_W-1:0]  right_index;
        logic [DIST_OUT_W-1:0] distance;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic append;
        logic query;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_sts;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int b = 0; b < 8; b++) begin
            c = c + 4'(v[b]);
        end
        return c;
    endfunction

    function automatic logic [WORD_CNT_W-1:0] popcount64(input logic [DESC_WORD_W-1:0] v);
        logic [WORD_CNT_W-1:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + WORD_CNT_W'(popcount8(v[k*8 +: 8]));
        end
        return c;
    endfunction

endpackage

// File: rtl/core/srhm_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher controller
// Sequences clear, append and query words and steps the scan of the store.
// ----------------------------------------------------------------------------
module srhm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [srhm_pkg::FUNC_W-1:0] i_func,
    output logic                       o_in_stall,
    input  srhm_pkg::t_sts             i_sts,
    output srhm_pkg::t_cmd             o_cmd
);
    import srhm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        FUNC_APPEND: begin
                            o_cmd.append = 1'b1;
                        end
                        FUNC_QUERY: begin
                            o_cmd.query = 1'b1;
                            n_state     = i_sts.empty ? ST_FINISH : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/srhm_datapath.sv
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher datapath
// Keypoint store, scan pipeline, best-candidate tracking and result register.
// ----------------------------------------------------------------------------
module srhm_datapath #(
    parameter int MAX_KEYPOINTS = srhm_pkg::MAX_KEYPOINTS_DEF,
    parameter int DESC_BITS     = srhm_pkg::DESC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  srhm_pkg::t_cmd                 i_cmd,
    output srhm_pkg::t_sts                 o_sts,
    input  srhm_pkg::t_in_word             i_in_word,
    input  logic                           i_cfg_wr_en,
    input  logic [srhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srhm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output srhm_pkg::t_out_word            o_out_word
);
    import srhm_pkg::*;

    localparam int IDX_W      = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_KEYPOINTS + 1);
    localparam int DESC_WORDS = (DESC_BITS + DESC_WORD_W - 1) / DESC_WORD_W;
    localparam int PAD_W      = DESC_WORDS * DESC_WORD_W;
    localparam int DIST_W     = $clog2(DESC_BITS + 1);
    localparam int ROW_W      = 2 * COORD_W + DESC_BITS;

    logic [CFG_DATA_W-1:0] r_max_distance;
    logic [TOL_W-1:0]      r_row_tol;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_addr;

    logic [COORD_W-1:0]    r_qx;
    logic [COORD_W-1:0]    r_qy;
    logic [DESC_BITS-1:0]  r_qdesc;

    logic [ROW_W-1:0]      mem [MAX_KEYPOINTS];

    logic                  r_s1_valid;
    logic [IDX_W-1:0]      r_s1_idx;
    logic [ROW_W-1:0]      r_s1_row;

    logic                  r_s2_valid;
    logic                  r_s2_inrow;
    logic [IDX_W-1:0]      r_s2_idx;
    logic [COORD_W-1:0]    r_s2_x;
    logic [WORD_CNT_W-1:0] r_s2_cnt [DESC_WORDS];

    logic                  r_found;
    logic [DIST_W-1:0]     r_best_dist;
    logic [IDX_W-1:0]      r_best_idx;
    logic [COORD_W-1:0]    r_best_x;

    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic [4*DESC_WORD_W-1:0] in_desc_full;
    logic [DESC_BITS-1:0]     in_desc;
    logic [ROW_W-1:0]         wr_row;
    logic                     not_full;

    logic [COORD_W-1:0]       s1_x;
    logic [COORD_W-1:0]       s1_y;
    logic [DESC_BITS-1:0]     s1_desc;
    logic [COORD_W-1:0]       s1_dy;
    logic [PAD_W-1:0]         s1_diff;
    logic [WORD_CNT_W-1:0]    s1_cnt [DESC_WORDS];

    logic [DIST_W-1:0]        n_dist;
    logic                     take_best;

    logic [DIST_OUT_W-1:0]    best_dist9;
    logic [IDX_W+IDX_OUT_W-1:0] best_idx_ext;
    t_out_word                n_out_word;

    assign in_desc_full = {i_in_word.desc_word3, i_in_word.desc_word2,
                           i_in_word.desc_word1, i_in_word.desc_word0};
    assign in_desc      = in_desc_full[DESC_BITS-1:0];
    assign wr_row       = {i_in_word.x_pos, i_in_word.y_pos, in_desc};
    assign not_full     = (r_count < CNT_W'(MAX_KEYPOINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= MAX_DISTANCE_RST;
            r_row_tol      <= ROW_TOL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MAX_DISTANCE: begin
                    r_max_distance <= i_cfg_data;
                end
                REG_ROW_TOLERANCE: begin
                    r_row_tol <= i_cfg_data[TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && not_full) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && not_full) begin
            mem[r_count[IDX_W-1:0]] <= wr_row;
        end
        if (i_cmd.issue) begin
            r_s1_row <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_qx    <= i_in_word.x_pos;
            r_qy    <= i_in_word.y_pos;
            r_qdesc <= in_desc;
            r_addr  <= '0;
        end else if (i_cmd.issue) begin
            r_addr  <= r_addr + 1'b1;
        end
        r_s1_idx <= r_addr;
    end

    assign s1_desc = r_s1_row[DESC_BITS-1:0];
    assign s1_y    = r_s1_row[DESC_BITS +: COORD_W];
    assign s1_x    = r_s1_row[DESC_BITS+COORD_W +: COORD_W];
    assign s1_dy   = (s1_y > r_qy) ? (s1_y - r_qy) : (r_qy - s1_y);
    assign s1_diff = PAD_W'(s1_desc ^ r_qdesc);

    for (genvar w = 0; w < DESC_WORDS; w++) begin : g_word
        assign s1_cnt[w] = popcount64(s1_diff[w*DESC_WORD_W +: DESC_WORD_W]);

        always_ff @(posedge i_clk) begin
            r_s2_cnt[w] <= s1_cnt[w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
        r_s2_inrow <= (s1_dy <= COORD_W'(r_row_tol));
        r_s2_idx   <= r_s1_idx;
        r_s2_x     <= s1_x;
    end

    always_comb begin
        n_dist = '0;
        for (int w = 0; w < DESC_WORDS; w++) begin
            n_dist = n_dist + DIST_W'(r_s2_cnt[w]);
        end
    end

    assign take_best = r_s2_valid && r_s2_inrow && (!r_found || (n_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.query) begin
            r_found <= 1'b0;
        end else if (take_best) begin
            r_found <= 1'b1;
        end
        if (take_best) begin
            r_best_dist <= n_dist;
            r_best_idx  <= r_s2_idx;
            r_best_x    <= r_s2_x;
        end
    end

    assign best_dist9   = DIST_OUT_W'(r_best_dist);
    assign best_idx_ext = (IDX_W+IDX_OUT_W)'(r_best_idx);

    always_comb begin
        n_out_word             = '0;
        n_out_word.status      = STATUS_NO_ROW;
        if (r_found) begin
            n_out_word.right_index = best_idx_ext[IDX_OUT_W-1:0];
            n_out_word.distance    = best_dist9;
            if (best_dist9 >= r_max_distance) begin
                n_out_word.status = STATUS_TOO_FAR;
            end else if (!(r_qx > r_best_x)) begin
                n_out_word.status = STATUS_NOT_LEFT;
            end else begin
                n_out_word.status = STATUS_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.last_issue = (CNT_W'(r_addr) == (r_count - 1'b1));
    assign o_sts.pipe_busy  = r_s1_valid || r_s2_valid;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule

// File: rtl/core/stereo_row_hamming_matcher.sv
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher
// Stores right keypoints and finds, per left query, the nearest descriptor
// on the same image row within a tolerance.
// ----------------------------------------------------------------------------
//  channel | handshake                | word
//  --------+--------------------------+---------------------------------
//  in      | i_in_valid / o_in_stall  | func, x_pos, y_pos, desc_word0-3
//  out     | o_out_valid / i_out_stall| status, right_index, distance
//  cfg     | i_cfg_wr_en              | i_cfg_index, i_cfg_data
//
// A query scans the keypoint memory through its single read port, one entry
// per cycle; for an empty set the scan is skipped. A stalled earlier result
// word delays the end of a query.
// No clearing pass follows reset; the block takes words at once.
// While a result word waits under stall, clear and append words still pass.
// ----------------------------------------------------------------------------
module stereo_row_hamming_matcher #(
    parameter int MAX_KEYPOINTS = srhm_pkg::MAX_KEYPOINTS_DEF,
    parameter int DESC_BITS     = srhm_pkg::DESC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  srhm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output srhm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_wr_en,
    input  logic [srhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srhm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srhm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    srhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_word.func),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    srhm_datapath #(
        .MAX_KEYPOINTS (MAX_KEYPOINTS),
        .DESC_BITS     (DESC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// File: rtl/core/srhm_checker.sv
// ----------------------------------------------------------------------------
// Stereo row Hamming matcher port checker
// Watches the matcher ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_row_hamming_matcher_defines.svh"

module srhm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input srhm_pkg::t_in_word             i_in_word,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input srhm_pkg::t_out_word            o_out_word,
    input logic                           i_cfg_wr_en,
    input logic [srhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [srhm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srhm_pkg::*;

    `SRHM_ASSERT_NEXT(a_query_blocks_input, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_word.func == FUNC_QUERY), o_in_stall)

    `SRHM_ASSERT_SAME(a_no_row_zero, i_clk, i_rst_n,
        o_out_valid && (o_out_word.status == STATUS_NO_ROW),
        (o_out_word.right_index == '0) && (o_out_word.distance == '0))

    `SRHM_ASSERT_SAME(a_distance_range, i_clk, i_rst_n,
        o_out_valid, o_out_word.distance <= 9'd256)

    `SRHM_ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

endmodule

bind stereo_row_hamming_matcher srhm_checker u_srhm_checker (.*);
